>>> rtl/rdq_pkg.sv
// Package: request and status codes, field widths and defaults for the reversible deque.
`timescale 1ns / 1ps
package rdq_pkg;

  localparam int DEFAULT_CAPACITY = 1024;
  localparam int DATA_W = 64;
  localparam int POS_W  = 10;
  localparam int OCC_W  = 11;

  typedef enum logic [2:0] {
    REQ_PUSH_L  = 3'd0,
    REQ_PUSH_R  = 3'd1,
    REQ_POP_L   = 3'd2,
    REQ_POP_R   = 3'd3,
    REQ_READ    = 3'd4,
    REQ_WRITE   = 3'd5,
    REQ_REVERSE = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef logic [OCC_W-1:0] occ_t;

endpackage

>>> rtl/rdq_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module rdq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> rtl/reversible_deque_unit.sv
// Top level: bounded double-ended queue of 64-bit values with constant-time reversal.
//
// Requests enter on the s_* stream: tuser carries the request type (push left/right,
// pop left/right, read, write, reverse), tdata the position and the data value.
// Every request yields exactly one result on the m_* stream: tuser carries the
// status, tdata the read value, the occupancy after the request and the empty flag.
// Pointer and count updates happen at the edge that accepts a request; the ring
// entry is written or read in the same cycle through the one RAM port.
// The result passes first through the stage that is filled alongside the registered
// RAM read, then through the result register.
// One request is accepted every cycle while s_tready is high; the single RAM port
// carries the one entry access, if any, that each request needs.
// When the receiver stalls, the result register holds and the stage behind it
// fills; s_tready drops only when both are full and m_tready is low.
// Reset clears the head pointer, count, reversal flag and both stages; the ring
// contents are not cleared, and only slots holding stored values are ever read.
`timescale 1ns / 1ps
module reversible_deque_unit
  import rdq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // position[9:0], data_in[73:10], zero pad[79:74]
  input  logic [2:0]  s_tuser,  // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // data_out[63:0], occupancy[74:64], is_empty[75], pad
  output logic [1:0]  m_tuser   // status[1:0]
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int SW   = CW + 1;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          flipped, flipped_next;

  logic              accept;
  req_t              req;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] din;
  status_t           status_c;
  logic              is_read_c;

  logic [CW-1:0]  k_off;
  logic [SW-1:0]  slot_sum;
  logic [AW-1:0]  slot;
  logic [AW-1:0]  head_dec;
  logic           ram_en, ram_we;
  logic [AW-1:0]  ram_addr;
  logic [DATA_W-1:0] ram_q;

  logic          p1_valid;
  status_t       p1_status;
  logic [CW-1:0] p1_occ;
  logic          p1_read;

  logic              out_valid;
  status_t           out_status;
  logic [DATA_W-1:0] out_data;
  occ_t              out_occ;
  logic              out_empty;

  logic advance;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !p1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  assign req = req_t'(s_tuser);
  assign pos = s_tdata[POS_W-1:0];
  assign din = s_tdata[POS_W +: DATA_W];

  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);

  always_comb begin
    k_off = count;
    if (req == REQ_READ || req == REQ_WRITE) begin
      k_off = flipped ? CW'(CMPW'(count) - CMPW'(1) - CMPW'(pos)) : CW'(pos);
    end
    slot_sum = SW'(head) + SW'(k_off);
    if (slot_sum >= SW'(CAPACITY)) begin
      slot_sum = slot_sum - SW'(CAPACITY);
    end
    slot = AW'(slot_sum);
  end

  always_comb begin
    head_next    = head;
    count_next   = count;
    flipped_next = flipped;
    status_c     = ST_OK;
    is_read_c    = 1'b0;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = slot;
    case (req) inside
      REQ_PUSH_L, REQ_PUSH_R: begin
        if (count >= CW'(CAPACITY)) begin
          status_c = ST_FULL;
        end else begin
          ram_en     = accept;
          ram_we     = 1'b1;
          count_next = count + CW'(1);
          if ((req == REQ_PUSH_L) != flipped) begin
            head_next = head_dec;
            ram_addr  = head_dec;
          end
        end
      end
      REQ_POP_L, REQ_POP_R: begin
        if (count == '0) begin
          status_c = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
          if ((req == REQ_POP_L) != flipped) begin
            head_next = (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);
          end
        end
      end
      REQ_READ, REQ_WRITE: begin
        if (CMPW'(pos) >= CMPW'(count)) begin
          status_c = ST_RANGE;
        end else begin
          ram_en    = accept;
          ram_we    = (req == REQ_WRITE);
          is_read_c = (req == REQ_READ);
        end
      end
      REQ_REVERSE: begin
        flipped_next = !flipped;
      end
      default: begin
      end
    endcase
  end

  rdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(din),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      flipped  <= 1'b0;
      p1_valid <= 1'b0;
    end else begin
      if (accept) begin
        head    <= head_next;
        count   <= count_next;
        flipped <= flipped_next;
      end
      if (s_tready) begin
        p1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_status <= status_c;
      p1_occ    <= count_next;
      p1_read   <= is_read_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && p1_valid) begin
      out_status <= p1_status;
      out_data   <= p1_read ? ram_q : '0;
      out_occ    <= occ_t'(p1_occ);
      out_empty  <= (p1_occ == '0);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {4'b0, out_empty, out_occ, out_data};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_data == '0)
    else $error("failed request carries data");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    accept && status_c != ST_OK |=> count == $past(count) && head == $past(head))
    else $error("failed request changed state");

  a_ram_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_en |-> CMPW'(ram_addr) < CMPW'(CAPACITY))
    else $error("ram address out of range");
`endif

endmodule
